// ===== design/kmes_pkg.sv =====
// Shared constants and types for the key matrix edge scanner.
package kmes_pkg;

   localparam int COLUMN_COUNT = 16;
   localparam int ROW_COUNT = 8;
   localparam int SAMPLE_W = 8;
   localparam int COLUMN_W = 4;
   localparam int ROW_W = 3;
   localparam int CFG_W = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(COLUMN_COUNT);
   localparam logic [CFG_W-1:0] CFG_MAX = CFG_W'(COLUMN_COUNT);
   localparam logic [CFG_W-1:0] CFG_MIN = CFG_W'(1);
   localparam logic [SAMPLE_W-1:0] ROW_MASK =
      (ROW_COUNT >= SAMPLE_W) ? {SAMPLE_W{1'b1}} : SAMPLE_W'((1 << ROW_COUNT) - 1);

   typedef struct packed {
      logic [COLUMN_W-1:0] column;
      logic [SAMPLE_W-1:0] sample;
      logic [SAMPLE_W-1:0] changed;
   } scan_entry_type;

endpackage

// ===== design/kmes_ifs.sv =====
// Channel interfaces for row samples, edge events and the configuration write.
interface kmes_req_if;
   logic                  valid;
   logic                  ready;
   logic [kmes_pkg::SAMPLE_W-1:0] row_sample;

   modport source (output valid, output row_sample, input ready);
   modport sink (input valid, input row_sample, output ready);
endinterface

interface kmes_rsp_if;
   logic                  valid;
   logic                  ready;
   logic [kmes_pkg::COLUMN_W-1:0] event_column;
   logic [kmes_pkg::ROW_W-1:0]    event_row;
   logic                  rising;
   logic                  last_event;

   modport source (output valid, output event_column, output event_row,
                   output rising, output last_event, input ready);
   modport sink (input valid, input event_column, input event_row,
                 input rising, input last_event, output ready);
endinterface

interface kmes_csr_if;
   logic                  valid;
   logic                  ready;
   logic [kmes_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== design/kmes_front.sv =====
// Front end: takes row samples, compares with the stored column state and walks the column.
module kmes_front import kmes_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   kmes_req_if.sink       req,
   kmes_csr_if.sink       csr,
   input  logic           queue_full,
   output logic           push_valid,
   output scan_entry_type push_entry
);

   logic [SAMPLE_W-1:0] prev_ff [COLUMN_COUNT];
   logic [COLUMN_W-1:0] column_ff;
   logic [COLUMN_W-1:0] column_in;
   logic [CFG_W-1:0]    columns_ff;
   logic [CFG_W-1:0]    active;
   logic [CFG_W-1:0]    column_next;
   logic [SAMPLE_W-1:0] sample;
   logic                accept;

   assign req.ready = !queue_full;
   assign csr.ready = 1'b1;
   assign accept = req.valid && req.ready;

   always_comb begin
      sample = req.row_sample & ROW_MASK;
      push_entry.column = column_ff;
      push_entry.sample = sample;
      push_entry.changed = sample ^ prev_ff[column_ff];
      push_valid = accept && (push_entry.changed != '0);

      if (columns_ff < CFG_MIN) begin
         active = CFG_MIN;
      end else if (columns_ff > CFG_MAX) begin
         active = CFG_MAX;
      end else begin
         active = columns_ff;
      end
      column_next = {1'b0, column_ff} + CFG_W'(1);
      if (column_next >= active) begin
         column_in = '0;
      end else begin
         column_in = column_next[COLUMN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         columns_ff <= CFG_RESET;
         for (int i = 0; i < COLUMN_COUNT; i++) begin
            prev_ff[i] <= '0;
         end
      end else begin
         if (csr.valid && csr.ready) begin
            columns_ff <= csr.data;
         end
         if (accept) begin
            prev_ff[column_ff] <= sample;
            column_ff <= column_in;
         end
      end
   end

endmodule

// ===== design/kmes_queue.sv =====
// Short queue of changed column samples between the front and back ends.
module kmes_queue import kmes_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  scan_entry_type push_entry,
   output logic           full,
   output logic           pop_valid,
   output scan_entry_type pop_entry,
   input  logic           pop_ready
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   scan_entry_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   logic              pop;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign push = push_valid && !full;
   assign pop = pop_valid && pop_ready;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== design/kmes_back.sv =====
// Back end: emits one edge event per cycle while rsp accepts, for each changed row, lowest row first.
module kmes_back import kmes_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   input  scan_entry_type pop_entry,
   output logic           pop_ready,
   kmes_rsp_if.source     rsp
);

   logic                work_valid_ff;
   logic [COLUMN_W-1:0] work_column_ff;
   logic [SAMPLE_W-1:0] work_sample_ff;
   logic [SAMPLE_W-1:0] work_mask_ff;
   logic                rsp_valid_ff;
   logic [COLUMN_W-1:0] column_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                rising_ff;
   logic                last_ff;
   logic [ROW_W-1:0]    row_sel;
   logic [SAMPLE_W-1:0] mask_rest;
   logic                out_free;
   logic                emit;
   logic                last;

   assign rsp.valid = rsp_valid_ff;
   assign rsp.event_column = column_ff;
   assign rsp.event_row = row_ff;
   assign rsp.rising = rising_ff;
   assign rsp.last_event = last_ff;

   always_comb begin
      row_sel = '0;
      for (int i = SAMPLE_W - 1; i >= 0; i--) begin
         if (work_mask_ff[i]) begin
            row_sel = ROW_W'(i);
         end
      end
      mask_rest = work_mask_ff & (work_mask_ff - SAMPLE_W'(1));
      last = (mask_rest == '0);
      out_free = !rsp_valid_ff || rsp.ready;
      emit = work_valid_ff && out_free;
      pop_ready = !work_valid_ff || (emit && last);
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         work_column_ff <= pop_entry.column;
         work_sample_ff <= pop_entry.sample;
         work_mask_ff <= pop_entry.changed;
      end else if (emit) begin
         work_mask_ff <= mask_rest;
      end
      if (emit) begin
         column_ff <= work_column_ff;
         row_ff <= row_sel;
         rising_ff <= work_sample_ff[row_sel];
         last_ff <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop_valid && pop_ready) begin
            work_valid_ff <= 1'b1;
         end else if (emit && last) begin
            work_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== design/key_matrix_edge_scanner.sv =====
// Top level of the key matrix edge scanner.
// Each req transaction carries the row sample of the column that the external walking
// one currently selects; the block tracks that column itself, starting at zero.
// The sample is compared with the stored sample of the same column, and one rsp
// transaction follows for each row that changed, lowest row first, giving column,
// row and direction; last_event marks the final event of a sample.
// A sample with no change produces no rsp transaction but still advances the column.
// The csr channel writes the number of columns in use; it is always ready.
// A sample is taken whenever the two-entry queue has room, so samples arrive back
// to back while the back end works. The first event of a sample passes the queue
// slot, the back end's work register and the output register on its way to rsp, and
// events follow one per cycle while rsp accepts; a sample yields zero to eight events.
// When rsp stalls, the output register holds its event, the back end waits, and the
// queue fills; req.ready then falls until an entry drains.
// Reset clears the stored samples, sets the column to zero and the column count to
// sixteen, and empties the queue and the output register.
module key_matrix_edge_scanner import kmes_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   kmes_req_if.sink   req,
   kmes_rsp_if.source rsp,
   kmes_csr_if.sink   csr
);

   logic           push_valid;
   scan_entry_type push_entry;
   logic           queue_full;
   logic           pop_valid;
   scan_entry_type pop_entry;
   logic           pop_ready;

   kmes_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .csr        (csr),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   kmes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   kmes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule
